@@ src/affine_transform_clip_stack_assert.svh @@
// Assertion macros for the affine clip stack RTL.
// Needs a clk and an active-low rst_n in the including module.
`ifndef AFFINE_TRANSFORM_CLIP_STACK_ASSERT_SVH
`define AFFINE_TRANSFORM_CLIP_STACK_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define ATCS_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked in the same cycle
`define ATCS_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle
`define ATCS_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/atcs_pkg.sv @@
// Shared types, codes and sizes for the affine clip stack.
// No dependencies; used by atcs_mac and the top level of the block.
package atcs_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int TOP_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int MAT_W       = 192;

    localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [15:0] CLAMP_MAX = 16'hFFFF;

    // Command codes
    localparam logic [2:0] ACT_CLIP_PUSH  = 3'd0;
    localparam logic [2:0] ACT_CLIP_POP   = 3'd1;
    localparam logic [2:0] ACT_XFORM_PUSH = 3'd2;
    localparam logic [2:0] ACT_XFORM_POP  = 3'd3;
    localparam logic [2:0] ACT_DRAW       = 3'd4;

    // Render-target operation codes
    localparam logic [2:0] OP_PUSH_CLIP  = 3'd0;
    localparam logic [2:0] OP_POP_CLIP   = 3'd1;
    localparam logic [2:0] OP_SET_MATRIX = 3'd2;
    localparam logic [2:0] OP_PUSH_LAYER = 3'd3;
    localparam logic [2:0] OP_POP_LAYER  = 3'd4;
    localparam logic [2:0] OP_DRAW       = 3'd5;
    localparam logic [2:0] OP_OVERFLOW   = 3'd6;

    // Multiplier schedule: last step of a push
    localparam logic [3:0] LAST_STEP = 4'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_EMIT
    } state_t;

    // a, b, c, d, tx, ty at indexes 0..5
    typedef logic [5:0][31:0] mat_t;

    typedef enum logic [1:0] {
        MK_SINGLE,
        MK_FIRST,
        MK_SECOND
    } mac_kind_t;

    typedef struct packed {
        logic               valid;
        logic [3:0]         tag;
        mac_kind_t          kind;
        logic signed [32:0] a;
        logic signed [32:0] b;
        logic signed [31:0] add;
    } mac_issue_t;

    typedef struct packed {
        logic               valid;
        logic [3:0]         tag;
        logic signed [31:0] value;
    } mac_res_t;

endpackage

@@ src/atcs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module atcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/atcs_mac.sv @@
// Shared multiply, pair-accumulate and round-saturate unit.
// Depends on atcs_pkg for the issue and result types.
module atcs_mac import atcs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  mac_issue_t iss,
    output mac_res_t   res
);

    logic               pvalid_reg;
    logic [3:0]         ptag_reg;
    mac_kind_t          pkind_reg;
    logic signed [65:0] prod_reg;
    logic signed [31:0] padd_reg;
    logic signed [65:0] first_reg;

    logic signed [66:0] total;
    logic signed [66:0] rounded;
    logic signed [50:0] quot;
    logic signed [51:0] sum52;
    logic signed [31:0] sat_val;

    // Hold product stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
        end
        else
        begin
            pvalid_reg <= iss.valid;
        end
    end

    // Multiply, keep the first product of a pair
    always_ff @(posedge clk)
    begin
        ptag_reg  <= iss.tag;
        pkind_reg <= iss.kind;
        padd_reg  <= iss.add;
        prod_reg  <= $signed(iss.a) * $signed(iss.b);
        if (pvalid_reg && pkind_reg == MK_FIRST)
        begin
            first_reg <= prod_reg;
        end
    end

    // Round half up to Q16.16, add the offset term, saturate
    always_comb
    begin
        total   = 67'(prod_reg) + ((pkind_reg == MK_SECOND) ? 67'(first_reg) : 67'sd0);
        rounded = total + 67'sd32768;
        quot    = rounded[66:16];
        sum52   = 52'(quot) + 52'(padd_reg);
        if (sum52 > 52'sd2147483647)
        begin
            sat_val = 32'sh7FFF_FFFF;
        end
        else if (sum52 < -52'sd2147483648)
        begin
            sat_val = 32'sh8000_0000;
        end
        else
        begin
            sat_val = sum52[31:0];
        end
        res.valid = pvalid_reg && (pkind_reg != MK_FIRST);
        res.tag   = ptag_reg;
        res.value = sat_val;
    end

endmodule

@@ src/affine_transform_clip_stack.sv @@
// Top level of the affine matrix stack with scroll clips.
// Depends on atcs_pkg, atcs_ram, atcs_mac and the assertion macro header.
//
// One render command is taken at a time; in_stall is high until its last
// request has been loaded into the output register. A clip or transform push
// that finds room on the stack runs ten products through the single shared
// 33x33 multiplier (the pivot terms, the four scaled elements and the two
// translation pairs), each product registered and then rounded, before its
// results are emitted. A pop that restores a saved frame first reads the stack
// memory; other commands go straight to emitting their results. Each
// result is held in an output register, so the stack may start the next
// command while the final result of the previous one waits to be taken.
// The saved matrices and clip flags live in two RAMs with registered reads.
module affine_transform_clip_stack import atcs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic signed [31:0] rect_x,
    input  logic signed [31:0] rect_y,
    input  logic signed [31:0] rect_w,
    input  logic signed [31:0] rect_h,
    input  logic signed [31:0] offset_x,
    input  logic signed [31:0] offset_y,
    input  logic signed [31:0] scale_factor,
    input  logic signed [31:0] pivot_x,
    input  logic signed [31:0] pivot_y,
    input  logic               subtree_clip,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         op,
    output logic signed [31:0] mat_a,
    output logic signed [31:0] mat_b,
    output logic signed [31:0] mat_c,
    output logic signed [31:0] mat_d,
    output logic signed [31:0] mat_tx,
    output logic signed [31:0] mat_ty,
    output logic signed [31:0] clip_left,
    output logic signed [31:0] clip_top,
    output logic signed [31:0] clip_right,
    output logic signed [31:0] clip_bottom,
    output logic               last
);

`include "affine_transform_clip_stack_assert.svh"

    state_t            state_reg, state_next;
    logic [TOP_W-1:0]  top_reg;
    logic [15:0]       clamp_reg;
    logic [31:0]       ovf_reg;
    logic [3:0]        step_reg;
    logic [1:0]        emit_idx_reg;
    logic [1:0]        cnt_reg;
    logic [2:0][2:0]   plan_reg;
    mat_t              cur_reg;
    mat_t              nxt_reg;
    logic              out_valid_reg;
    logic [2:0]        act_reg;
    logic              clip_mode_reg;

    logic [31:0]       rx_reg, ry_reg, rw_reg, rh_reg;
    logic signed [31:0] ox_reg, oy_reg, sc_reg, px_reg, py_reg;
    logic signed [31:0] lx_reg, ly_reg;

    logic [2:0]        op_reg;
    logic [31:0]       ma_reg, mb_reg, mc_reg, md_reg, mtx_reg, mty_reg;
    logic [31:0]       cl_reg, ct_reg, cr_reg, cb_reg;
    logic              last_reg;

    logic              accept;
    logic              slot_free;
    logic              full;
    logic              mram_we, fram_we, ram_re;
    logic [IDX_W-1:0]  waddr, raddr;
    logic [TOP_W-1:0]  top_dec;
    mat_t              mram_rdata;
    logic              fram_rdata;
    mat_t              ident;
    mac_issue_t        iss;
    mac_res_t          res;
    logic signed [32:0] s_eff, one_minus_s;
    logic signed [31:0] neg_ox, neg_oy;
    logic [2:0]        emit_op;
    logic              emit_mat, emit_clip;

    // Stack memories
    atcs_ram #(.WIDTH(MAT_W), .DEPTH(STACK_DEPTH)) u_mat_ram (
        .clk   (clk),
        .we    (mram_we),
        .waddr (waddr),
        .wdata (cur_reg),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (mram_rdata)
    );

    atcs_ram #(.WIDTH(1), .DEPTH(STACK_DEPTH)) u_flag_ram (
        .clk   (clk),
        .we    (fram_we),
        .waddr (waddr),
        .wdata (subtree_clip),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (fram_rdata)
    );

    // Shared multiplier
    atcs_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .iss   (iss),
        .res   (res)
    );

    // Handshake and stack addressing
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        accept    = in_valid && !in_stall;
        slot_free = !out_valid_reg || !out_stall;
        full      = (top_reg >= TOP_W'(STACK_DEPTH));
        top_dec   = top_reg - TOP_W'(1);
        waddr     = top_reg[IDX_W-1:0];
        raddr     = top_dec[IDX_W-1:0];
        mram_we   = accept && !full
                    && (action == ACT_CLIP_PUSH || action == ACT_XFORM_PUSH);
        fram_we   = accept && !full && (action == ACT_XFORM_PUSH);
        ram_re    = accept && (clamp_reg == 16'd0) && (top_reg != '0)
                    && (action == ACT_CLIP_POP || action == ACT_XFORM_POP);
        ident     = '0;
        ident[0]  = ONE_Q16;
        ident[3]  = ONE_Q16;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_CLIP_PUSH, ACT_XFORM_PUSH:
                            state_next = full ? ST_EMIT : ST_CALC;
                        ACT_CLIP_POP, ACT_XFORM_POP:
                            state_next = ram_re ? ST_READ : ST_EMIT;
                        ACT_DRAW:
                            state_next = ST_EMIT;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:
                state_next = ST_EMIT;
            ST_CALC:
            begin
                if (res.valid && res.tag == LAST_STEP)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free && emit_idx_reg == cnt_reg - 2'd1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Multiplier operand schedule
    always_comb
    begin
        s_eff       = clip_mode_reg ? 33'sd65536 : 33'(sc_reg);
        one_minus_s = 33'sd65536 - 33'(sc_reg);
        neg_ox      = (ox_reg == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -ox_reg;
        neg_oy      = (oy_reg == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -oy_reg;
        iss.valid   = (state_reg == ST_CALC) && (step_reg <= LAST_STEP);
        iss.tag     = step_reg;
        iss.kind    = MK_SINGLE;
        iss.a       = '0;
        iss.b       = '0;
        iss.add     = '0;
        case (step_reg)
            4'd0:
            begin
                iss.a   = clip_mode_reg ? 33'sd0 : 33'(px_reg);
                iss.b   = clip_mode_reg ? 33'sd0 : one_minus_s;
                iss.add = clip_mode_reg ? neg_ox : ox_reg;
            end
            4'd1:
            begin
                iss.a   = clip_mode_reg ? 33'sd0 : 33'(py_reg);
                iss.b   = clip_mode_reg ? 33'sd0 : one_minus_s;
                iss.add = clip_mode_reg ? neg_oy : oy_reg;
            end
            4'd2, 4'd3, 4'd4, 4'd5:
            begin
                iss.a = s_eff;
                iss.b = 33'($signed(cur_reg[step_reg[1:0] - 2'd2]));
            end
            4'd6:
            begin
                iss.kind = MK_FIRST;
                iss.a    = 33'(lx_reg);
                iss.b    = 33'($signed(cur_reg[0]));
            end
            4'd7:
            begin
                iss.kind = MK_SECOND;
                iss.a    = 33'(ly_reg);
                iss.b    = 33'($signed(cur_reg[2]));
                iss.add  = cur_reg[4];
            end
            4'd8:
            begin
                iss.kind = MK_FIRST;
                iss.a    = 33'(lx_reg);
                iss.b    = 33'($signed(cur_reg[1]));
            end
            4'd9:
            begin
                iss.kind = MK_SECOND;
                iss.a    = 33'(ly_reg);
                iss.b    = 33'($signed(cur_reg[3]));
                iss.add  = cur_reg[5];
            end
            default:
            begin
                iss.kind = MK_SINGLE;
            end
        endcase
    end

    // Control state, counters and current matrix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_reg       <= '0;
            clamp_reg     <= '0;
            ovf_reg       <= '0;
            step_reg      <= '0;
            emit_idx_reg  <= '0;
            cnt_reg       <= '0;
            plan_reg      <= '0;
            cur_reg       <= {32'd0, 32'd0, ONE_Q16, 32'd0, 32'd0, ONE_Q16};
            out_valid_reg <= 1'b0;
            act_reg       <= '0;
            clip_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Drop the output once taken, load it when emitting
            if (state_reg == ST_EMIT && slot_free)
            begin
                out_valid_reg <= 1'b1;
                emit_idx_reg  <= emit_idx_reg + 2'd1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                act_reg      <= action;
                emit_idx_reg <= '0;
                step_reg     <= '0;
                case (action)
                    ACT_CLIP_PUSH:
                    begin
                        cnt_reg <= 2'd2;
                        if (full)
                        begin
                            if (clamp_reg != CLAMP_MAX)
                            begin
                                clamp_reg <= clamp_reg + 16'd1;
                            end
                            ovf_reg     <= ovf_reg + 32'd1;
                            plan_reg[0] <= OP_OVERFLOW;
                            plan_reg[1] <= OP_PUSH_CLIP;
                        end
                        else
                        begin
                            top_reg       <= top_reg + TOP_W'(1);
                            clip_mode_reg <= 1'b1;
                            plan_reg[0]   <= OP_PUSH_CLIP;
                            plan_reg[1]   <= OP_SET_MATRIX;
                        end
                    end
                    ACT_CLIP_POP:
                    begin
                        if (clamp_reg != 16'd0)
                        begin
                            clamp_reg   <= clamp_reg - 16'd1;
                            cnt_reg     <= 2'd1;
                            plan_reg[0] <= OP_POP_CLIP;
                        end
                        else if (top_reg != '0)
                        begin
                            top_reg <= top_dec;
                        end
                        else
                        begin
                            cur_reg     <= ident;
                            cnt_reg     <= 2'd2;
                            plan_reg[0] <= OP_SET_MATRIX;
                            plan_reg[1] <= OP_POP_CLIP;
                        end
                    end
                    ACT_XFORM_PUSH:
                    begin
                        plan_reg[0] <= OP_PUSH_LAYER;
                        if (full)
                        begin
                            if (clamp_reg != CLAMP_MAX)
                            begin
                                clamp_reg <= clamp_reg + 16'd1;
                            end
                            ovf_reg     <= ovf_reg + 32'd1;
                            cnt_reg     <= 2'd2;
                            plan_reg[1] <= OP_OVERFLOW;
                        end
                        else
                        begin
                            top_reg       <= top_reg + TOP_W'(1);
                            clip_mode_reg <= 1'b0;
                            if (subtree_clip)
                            begin
                                cnt_reg     <= 2'd3;
                                plan_reg[1] <= OP_PUSH_CLIP;
                                plan_reg[2] <= OP_SET_MATRIX;
                            end
                            else
                            begin
                                cnt_reg     <= 2'd2;
                                plan_reg[1] <= OP_SET_MATRIX;
                            end
                        end
                    end
                    ACT_XFORM_POP:
                    begin
                        if (clamp_reg != 16'd0)
                        begin
                            clamp_reg   <= clamp_reg - 16'd1;
                            cnt_reg     <= 2'd1;
                            plan_reg[0] <= OP_POP_LAYER;
                        end
                        else if (top_reg != '0)
                        begin
                            top_reg <= top_dec;
                        end
                        else
                        begin
                            cnt_reg     <= 2'd1;
                            plan_reg[0] <= OP_POP_LAYER;
                        end
                    end
                    ACT_DRAW:
                    begin
                        cnt_reg     <= 2'd1;
                        plan_reg[0] <= OP_DRAW;
                    end
                    default:
                    begin
                        cnt_reg <= '0;
                    end
                endcase
            end

            // Restore the saved frame
            if (state_reg == ST_READ)
            begin
                cur_reg     <= mram_rdata;
                plan_reg[0] <= OP_SET_MATRIX;
                if (act_reg == ACT_CLIP_POP)
                begin
                    cnt_reg     <= 2'd2;
                    plan_reg[1] <= OP_POP_CLIP;
                end
                else if (fram_rdata)
                begin
                    cnt_reg     <= 2'd3;
                    plan_reg[1] <= OP_POP_CLIP;
                    plan_reg[2] <= OP_POP_LAYER;
                end
                else
                begin
                    cnt_reg     <= 2'd2;
                    plan_reg[1] <= OP_POP_LAYER;
                end
            end

            // Advance the multiplier schedule and commit the new matrix
            if (iss.valid)
            begin
                step_reg <= step_reg + 4'd1;
            end
            if (state_reg == ST_CALC && res.valid && res.tag == LAST_STEP)
            begin
                cur_reg <= {res.value, nxt_reg[4], nxt_reg[3], nxt_reg[2],
                            nxt_reg[1], nxt_reg[0]};
            end
        end
    end

    // Latch the request and collect multiplier results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rx_reg  <= rect_x;
            ry_reg  <= rect_y;
            rw_reg  <= rect_w;
            rh_reg  <= rect_h;
            ox_reg  <= offset_x;
            oy_reg  <= offset_y;
            sc_reg  <= scale_factor;
            px_reg  <= pivot_x;
            py_reg  <= pivot_y;
        end
        if (res.valid)
        begin
            case (res.tag)
                4'd0:    lx_reg     <= res.value;
                4'd1:    ly_reg     <= res.value;
                4'd2:    nxt_reg[0] <= res.value;
                4'd3:    nxt_reg[1] <= res.value;
                4'd4:    nxt_reg[2] <= res.value;
                4'd5:    nxt_reg[3] <= res.value;
                4'd7:    nxt_reg[4] <= res.value;
                default: nxt_reg[5] <= res.value;
            endcase
        end
    end

    // Output register
    always_comb
    begin
        emit_op   = plan_reg[emit_idx_reg];
        emit_mat  = (emit_op == OP_SET_MATRIX) || (emit_op == OP_DRAW);
        emit_clip = (emit_op == OP_PUSH_CLIP);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && slot_free)
        begin
            op_reg   <= emit_op;
            ma_reg   <= emit_mat ? cur_reg[0] : 32'd0;
            mb_reg   <= emit_mat ? cur_reg[1] : 32'd0;
            mc_reg   <= emit_mat ? cur_reg[2] : 32'd0;
            md_reg   <= emit_mat ? cur_reg[3] : 32'd0;
            mtx_reg  <= emit_mat ? cur_reg[4] : 32'd0;
            mty_reg  <= emit_mat ? cur_reg[5] : 32'd0;
            cl_reg   <= emit_clip ? rx_reg : 32'd0;
            ct_reg   <= emit_clip ? ry_reg : 32'd0;
            cr_reg   <= emit_clip ? (rx_reg + rw_reg) : 32'd0;
            cb_reg   <= emit_clip ? (ry_reg + rh_reg) : 32'd0;
            last_reg <= (emit_idx_reg == cnt_reg - 2'd1);
        end
    end

    assign out_valid   = out_valid_reg;
    assign op          = op_reg;
    assign mat_a       = ma_reg;
    assign mat_b       = mb_reg;
    assign mat_c       = mc_reg;
    assign mat_d       = md_reg;
    assign mat_tx      = mtx_reg;
    assign mat_ty      = mty_reg;
    assign clip_left   = cl_reg;
    assign clip_top    = ct_reg;
    assign clip_right  = cr_reg;
    assign clip_bottom = cb_reg;
    assign last        = last_reg;

    // Checks on stack bookkeeping and sequencing
    `ATCS_ALWAYS(a_top_bound, top_reg <= TOP_W'(STACK_DEPTH), "stack top beyond depth")
    `ATCS_IMPLIES(a_clamp_full, clamp_reg != 16'd0, top_reg == TOP_W'(STACK_DEPTH), "clamped with room on stack")
    `ATCS_NEXT(a_calc_done, state_reg == ST_CALC && res.valid && res.tag == LAST_STEP, state_reg == ST_EMIT, "push result not emitted")
    `ATCS_IMPLIES(a_mac_idle, res.valid, state_reg == ST_CALC, "multiplier result outside push")

endmodule

@@ tb/tb_affine_transform_clip_stack.sv @@
// Testbench for the affine matrix stack with scroll clips and layered transforms.
// Depends on atcs_pkg and the affine_transform_clip_stack RTL.
// Commands are queued and scored up front by a behavioral matrix-stack model.
module tb_affine_transform_clip_stack;
    import atcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM = 135;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;

    typedef longint affine6_t [6];

    typedef struct {
        logic [2:0]  action;
        logic [31:0] rx, ry, rw, rh, ox, oy, scale, px, py;
        logic        subtree;
    } command_t;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] m [6];
        logic [31:0] cl, ct, cr, cb;
        logic        last;
    } render_op_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] action = '0;
    logic signed [31:0] rect_x = '0, rect_y = '0, rect_w = '0, rect_h = '0;
    logic signed [31:0] offset_x = '0, offset_y = '0, scale_factor = '0;
    logic signed [31:0] pivot_x = '0, pivot_y = '0;
    logic subtree_clip = 1'b0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic [2:0] op;
    logic signed [31:0] mat_a, mat_b, mat_c, mat_d, mat_tx, mat_ty;
    logic signed [31:0] clip_left, clip_top, clip_right, clip_bottom;
    logic last;

    affine_transform_clip_stack dut (.*);

    always #5 clk = ~clk;

    // Model state of the matrix stack
    affine6_t cur_matrix;
    affine6_t saved_matrix [STACK_DEPTH];
    logic     saved_flag [STACK_DEPTH];
    logic     flag_written [STACK_DEPTH];
    int       depth;
    int       clamp_cnt;

    command_t   pending_cmds [$];
    render_op_t expected_ops [$];
    bit  failed = 1'b0;
    bit  calm = 1'b0;
    int  idle_cycles = 0;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Round half up of (p + q) / 2^16, plus add, saturated
    function automatic longint round_sum(longint p, longint q, longint add);
        longint hp, hq;
        hp = p >>> 16;
        hq = q >>> 16;
        return sat32(hp + hq + add + (((p - (hp <<< 16)) + (q - (hq <<< 16)) + 32768) >>> 16));
    endfunction

    function automatic affine6_t identity_matrix();
        affine6_t m;
        m = '{65536, 0, 0, 65536, 0, 0};
        return m;
    endfunction

    // Row-vector product l * c
    function automatic affine6_t compose(affine6_t l, affine6_t c);
        affine6_t m;
        m[0] = round_sum(l[0] * c[0], l[1] * c[2], 0);
        m[1] = round_sum(l[0] * c[1], l[1] * c[3], 0);
        m[2] = round_sum(l[2] * c[0], l[3] * c[2], 0);
        m[3] = round_sum(l[2] * c[1], l[3] * c[3], 0);
        m[4] = round_sum(l[4] * c[0], l[5] * c[2], c[4]);
        m[5] = round_sum(l[4] * c[1], l[5] * c[3], c[5]);
        return m;
    endfunction

    function automatic void expect_op(logic [2:0] code, bit with_m, affine6_t m,
                                      bit with_clip, command_t c);
        render_op_t r;
        r.op = code;
        for (int i = 0; i < 6; i++)
            r.m[i] = with_m ? m[i][31:0] : '0;
        r.cl = with_clip ? c.rx : '0;
        r.ct = with_clip ? c.ry : '0;
        r.cr = with_clip ? c.rx + c.rw : '0;
        r.cb = with_clip ? c.ry + c.rh : '0;
        r.last = 1'b0;
        expected_ops.push_back(r);
    endfunction

    // Advance the model by one command and queue the render ops it causes
    function automatic void predict_ops(command_t c);
        affine6_t loc, none;
        int prior_count;
        longint s;
        prior_count = expected_ops.size();
        none = '{0, 0, 0, 0, 0, 0};
        case (c.action)
            ACT_CLIP_PUSH: begin
                if (depth >= STACK_DEPTH) begin
                    if (clamp_cnt < 65535) clamp_cnt++;
                    expect_op(OP_OVERFLOW, 0, none, 0, c);
                    expect_op(OP_PUSH_CLIP, 0, none, 1, c);
                end
                else begin
                    saved_matrix[depth] = cur_matrix;
                    depth++;
                    expect_op(OP_PUSH_CLIP, 0, none, 1, c);
                    loc = identity_matrix();
                    loc[4] = sat32(-longint'(signed'(c.ox)));
                    loc[5] = sat32(-longint'(signed'(c.oy)));
                    cur_matrix = compose(loc, cur_matrix);
                    expect_op(OP_SET_MATRIX, 1, cur_matrix, 0, c);
                end
            end
            ACT_CLIP_POP: begin
                if (clamp_cnt > 0)
                    clamp_cnt--;
                else
                begin
                    if (depth > 0)
                    begin
                        depth--;
                        cur_matrix = saved_matrix[depth];
                    end
                    else
                        cur_matrix = identity_matrix();
                    expect_op(OP_SET_MATRIX, 1, cur_matrix, 0, c);
                end
                expect_op(OP_POP_CLIP, 0, none, 0, c);
            end
            ACT_XFORM_PUSH: begin
                expect_op(OP_PUSH_LAYER, 0, none, 0, c);
                if (depth >= STACK_DEPTH) begin
                    if (clamp_cnt < 65535) clamp_cnt++;
                    expect_op(OP_OVERFLOW, 0, none, 0, c);
                end
                else begin
                    s = longint'(signed'(c.scale));
                    saved_matrix[depth] = cur_matrix;
                    saved_flag[depth] = c.subtree;
                    flag_written[depth] = 1'b1;
                    if (c.subtree) expect_op(OP_PUSH_CLIP, 0, none, 1, c);
                    depth++;
                    loc = '{s, 0, 0, s, 0, 0};
                    loc[4] = round_sum(longint'(signed'(c.px)) * (65536 - s), 0,
                                       longint'(signed'(c.ox)));
                    loc[5] = round_sum(longint'(signed'(c.py)) * (65536 - s), 0,
                                       longint'(signed'(c.oy)));
                    cur_matrix = compose(loc, cur_matrix);
                    expect_op(OP_SET_MATRIX, 1, cur_matrix, 0, c);
                end
            end
            ACT_XFORM_POP: begin
                if (clamp_cnt > 0)
                    clamp_cnt--;
                else if (depth > 0) begin
                    depth--;
                    cur_matrix = saved_matrix[depth];
                    expect_op(OP_SET_MATRIX, 1, cur_matrix, 0, c);
                    if (saved_flag[depth]) expect_op(OP_POP_CLIP, 0, none, 0, c);
                end
                expect_op(OP_POP_LAYER, 0, none, 0, c);
            end
            ACT_DRAW: expect_op(OP_DRAW, 1, cur_matrix, 0, c);
            default: ;
        endcase
        if (expected_ops.size() > prior_count)
            expected_ops[expected_ops.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 7))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return '0;
            3: return ONE_Q16;
            4, 5: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
            default: return $urandom;
        endcase
    endfunction

    // Queue one command; a transform pop onto a frame whose flag was never set turns into a clip pop
    function automatic void add_cmd(logic [2:0] act, logic [31:0] ox, logic [31:0] oy,
                                    logic [31:0] sc, logic sub);
        command_t c;
        c.action = act;
        c.rx = pick_q16();
        c.ry = pick_q16();
        c.rw = pick_q16();
        c.rh = pick_q16();
        c.ox = ox;
        c.oy = oy;
        c.scale = sc;
        c.px = pick_q16();
        c.py = pick_q16();
        c.subtree = sub;
        if (act == ACT_XFORM_POP && clamp_cnt == 0 && depth > 0 && !flag_written[depth - 1])
            c.action = ACT_CLIP_POP;
        predict_ops(c);
        pending_cmds.push_back(c);
    endfunction

    // Drive commands; hold a stalled request, then wait a drawn gap
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        command_t c;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && in_stall)
            ;
        else if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_cmds.size() > 0)
        begin
            c = pending_cmds.pop_front();
            action <= c.action;
            rect_x <= c.rx;
            rect_y <= c.ry;
            rect_w <= c.rw;
            rect_h <= c.rh;
            offset_x <= c.ox;
            offset_y <= c.oy;
            scale_factor <= c.scale;
            pivot_x <= c.px;
            pivot_y <= c.py;
            subtree_clip <= c.subtree;
            in_valid <= 1'b1;
            gap_left <= calm ? 0 : $urandom_range(0, 9);
        end
        else
            in_valid <= 1'b0;
    end

    // Check each taken render op against the oldest expected one
    int stall_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        render_op_t e;
        int n;
        logic [31:0] got [6];
        if (!rst_n)
            out_stall <= 1'b1;
        else
        begin
            if (out_valid && !out_stall)
            begin
                idle_cycles <= 0;
                got = '{mat_a, mat_b, mat_c, mat_d, mat_tx, mat_ty};
                if (expected_ops.size() == 0)
                begin
                    $display("%0t: unexpected op %0d", $realtime, op);
                    failed = 1'b1;
                end
                else
                begin
                    e = expected_ops.pop_front();
                    if (op !== e.op || last !== e.last || clip_left !== e.cl ||
                        clip_top !== e.ct || clip_right !== e.cr || clip_bottom !== e.cb ||
                        got != e.m)
                    begin
                        $display("%0t: expected op %0d last %0d clip %h %h %h %h mat %h %h %h %h %h %h",
                                 $realtime, e.op, e.last, e.cl, e.ct, e.cr, e.cb,
                                 e.m[0], e.m[1], e.m[2], e.m[3], e.m[4], e.m[5]);
                        $display("%0t: actual   op %0d last %0d clip %h %h %h %h mat %h %h %h %h %h %h",
                                 $realtime, op, last, clip_left, clip_top, clip_right,
                                 clip_bottom, got[0], got[1], got[2], got[3], got[4], got[5]);
                        failed = 1'b1;
                    end
                end
                n = calm ? 0 : $urandom_range(0, 9);
                stall_left <= n;
                out_stall <= (n != 0);
            end
            else
            begin
                if (in_valid && !in_stall)
                    idle_cycles <= 0;
                else
                    idle_cycles <= idle_cycles + 1;
                if (stall_left > 0) stall_left <= stall_left - 1;
                out_stall <= (stall_left > 1);
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        int climbing, count;
        logic [2:0] act;
        logic [31:0] sc;
        cur_matrix = identity_matrix();
        depth = 0;
        clamp_cnt = 0;
        for (int i = 0; i < STACK_DEPTH; i++)
            flag_written[i] = 1'b0;

        // Directed: extremes, empty-stack pops, unused codes, scale extremes
        add_cmd(ACT_DRAW, 0, 0, ONE_Q16, 0);
        add_cmd(ACT_CLIP_POP, 0, 0, ONE_Q16, 0);
        add_cmd(ACT_XFORM_POP, 0, 0, ONE_Q16, 0);
        add_cmd(ACT_CLIP_PUSH, Q_MIN, Q_MAX, ONE_Q16, 0);
        add_cmd(ACT_DRAW, 0, 0, ONE_Q16, 0);
        add_cmd(ACT_XFORM_PUSH, Q_MAX, Q_MIN, ONE_Q16, 1);
        add_cmd(ACT_XFORM_PUSH, 32'h0001_8000, 0, Q_MAX, 0);
        add_cmd(ACT_XFORM_PUSH, 0, 32'hFFFF_0000, Q_MIN, 1);
        add_cmd(ACT_DRAW, 0, 0, ONE_Q16, 0);
        add_cmd(3'd5, Q_MAX, Q_MAX, Q_MAX, 1);
        add_cmd(3'd6, 0, 0, 0, 0);
        add_cmd(3'd7, Q_MIN, Q_MIN, Q_MIN, 1);
        add_cmd(ACT_XFORM_POP, 0, 0, ONE_Q16, 0);
        add_cmd(ACT_XFORM_POP, 0, 0, ONE_Q16, 0);
        add_cmd(ACT_XFORM_POP, 0, 0, ONE_Q16, 0);
        add_cmd(ACT_CLIP_POP, 0, 0, ONE_Q16, 0);
        add_cmd(ACT_XFORM_PUSH, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_8000, 1);
        add_cmd(ACT_CLIP_PUSH, 0, 0, ONE_Q16, 0);
        add_cmd(ACT_DRAW, 0, 0, ONE_Q16, 0);
        add_cmd(ACT_CLIP_POP, 0, 0, ONE_Q16, 0);
        add_cmd(ACT_XFORM_POP, 0, 0, ONE_Q16, 0);

        // Random: alternate climbing to overflow and unwinding past empty
        climbing = 1;
        count = 0;
        while (count < NUM_RANDOM)
        begin
            if (depth >= STACK_DEPTH && clamp_cnt >= 2) climbing = 0;
            if (depth == 0 && $urandom_range(0, 3) == 0) climbing = 1;
            case ($urandom_range(0, 19))
                0: act = 3'($urandom_range(5, 7));
                1, 2: act = ACT_DRAW;
                3, 4, 5, 6, 7, 8, 9, 10, 11, 12:
                    act = climbing ? ($urandom_range(0, 1) ? ACT_CLIP_PUSH : ACT_XFORM_PUSH)
                                   : ($urandom_range(0, 1) ? ACT_CLIP_POP : ACT_XFORM_POP);
                default: act = 3'($urandom_range(0, 3));
            endcase
            sc = $urandom_range(0, 3) == 0 ? pick_q16()
                                          : ONE_Q16 + 32'($urandom_range(0, 1 << 16)) - 32'(1 << 15);
            add_cmd(act, pick_q16(), pick_q16(), sc, 1'($urandom));
            if (act <= ACT_DRAW) count++;
            if (count % 30 == 0) climbing = 1;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Toggle stretches without idling while commands drain
        while (pending_cmds.size() > 0 || in_valid || expected_ops.size() > 0)
        begin
            @(posedge clk);
            if ($urandom_range(0, 99) == 0) calm <= !calm;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed && expected_ops.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
